// File: src/boig_pkg.sv
// shared constants for the bisection order index generator
`default_nettype none

package boig_pkg;

    // register file geometry
    localparam int COUNT_W   = 11;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_SEL_W = PADDR_W - 2;

    // register word indexes
    localparam logic [REG_SEL_W-1:0] REG_COUNT = 1'b0;

    // reset value of the count register
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    // result field widths
    localparam int INDEX_W    = 10;
    localparam int POSITION_W = 10;

    // widest gap that is split by taking the next index rather than the midpoint
    localparam logic [COUNT_W-1:0] GAP_NEAR = 11'd3;

endpackage

`default_nettype wire

// File: src/boig_if.sv
// request and result channel interfaces
`default_nettype none

interface boig_req_if import boig_pkg::*; ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface boig_res_if import boig_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [INDEX_W-1:0]    index;
    logic [POSITION_W-1:0] position;
    logic                  last;

    modport source (output valid, output index, output position, output last, input ready);
    modport sink (input valid, input index, input position, input last, output ready);
endinterface

`default_nettype wire

// File: src/bisection_order_index_gen.sv
// Bisection order index generator, top level.
// Each transfer on req asks for the next index of 0..count-1 in bisection
// order; restart=1 begins a new sequence, as does the first request after
// reset and any request after the final index. Each request produces exactly
// one transfer on res carrying index, position and last.
// count is written over the APB port at byte address 0 and latched at the
// start of each sequence; write it only while the block is idle.
// From the req transfer, the first two indices of a sequence go from idle
// straight to the emit step; any other index passes the scan step, one read
// per unit gap or wrap stepped over, then the link step, then emit.
// One request is in flight at a time; req is ready again the cycle after the
// result is loaded. The rate is set by the successor memory: one read per
// step of the list walk, and two writes through its single write port for
// every splice.
// The result sits in an output register, so the next request is taken while
// a result waits; a stalled receiver holds the block only when a second result
// is ready to load. Reset clears the sequencer and sets count to 1024; the
// successor memory needs no clearing since every entry is written before use.
`default_nettype none

module bisection_order_index_gen import boig_pkg::*; #(
    parameter int MAX_COUNT = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    boig_req_if.sink                req,
    boig_res_if.source              res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int AW = $clog2(MAX_COUNT);

    logic [COUNT_W-1:0] cfg_count;
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [AW-1:0]      ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [AW-1:0]      ram_rd_data;

    // configuration registers
    boig_apb u_apb (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg_count (cfg_count)
    );

    // list walker
    boig_seq #(
        .MAX_COUNT (MAX_COUNT)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_count   (cfg_count),
        .req         (req),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // successor list storage
    boig_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_COUNT)
    ) u_succ_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// File: src/boig_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module boig_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/boig_apb.sv
// apb register block holding the count register
`default_nettype none

module boig_apb import boig_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [COUNT_W-1:0] cfg_count
);

    logic [COUNT_W-1:0]   count_reg;
    logic [REG_SEL_W-1:0] reg_sel;
    logic                 wr_transfer;

    assign reg_sel     = paddr[PADDR_W-1:2];
    assign pready      = 1'b1;
    assign wr_transfer = psel && penable && pwrite && pready;

    // count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (wr_transfer && reg_sel == REG_COUNT)
        begin
            count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            REG_COUNT: prdata = PDATA_W'(count_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg_count = count_reg;

endmodule

`default_nettype wire

// File: src/boig_seq.sv
// sequencer walking the successor list and splicing in new indices
`default_nettype none

module boig_seq import boig_pkg::*; #(
    parameter int MAX_COUNT = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [COUNT_W-1:0]            cfg_count,
    boig_req_if.sink                           req,
    boig_res_if.source                         res,
    output logic                               ram_wr_en,
    output logic [$clog2(MAX_COUNT)-1:0]       ram_wr_addr,
    output logic [$clog2(MAX_COUNT)-1:0]       ram_wr_data,
    output logic                               ram_rd_en,
    output logic [$clog2(MAX_COUNT)-1:0]       ram_rd_addr,
    input  wire logic [$clog2(MAX_COUNT)-1:0]  ram_rd_data
);

    localparam int AW = $clog2(MAX_COUNT);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LINK = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    active_reg, active_next;
    logic [COUNT_W-1:0]    emitted_reg, emitted_next;
    logic [COUNT_W-1:0]    cursor_reg, cursor_next;
    logic [COUNT_W-1:0]    c_reg, c_next;
    logic [COUNT_W-1:0]    pick_reg, pick_next;
    logic                  out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]    out_index_reg, out_index_next;
    logic [POSITION_W-1:0] out_position_reg, out_position_next;
    logic                  out_last_reg, out_last_next;

    logic [COUNT_W-1:0]    eff_count;
    logic [COUNT_W-1:0]    nm1;
    logic                  start_seq;
    logic [COUNT_W-1:0]    c_first;
    logic [COUNT_W-1:0]    nx_raw;
    logic [COUNT_W-1:0]    nx;
    logic                  gap_unit;
    logic [COUNT_W-1:0]    c_skip;
    logic [COUNT_W-1:0]    gap;
    logic [COUNT_W:0]      mid_sum;
    logic [COUNT_W-1:0]    pick;
    logic                  emit_last;

    // count latched at sequence start: zero reads as one, saturates at the depth
    always_comb
    begin
        if (cfg_count == '0)
        begin
            eff_count = COUNT_W'(1);
        end
        else if (32'(cfg_count) > MAX_COUNT)
        begin
            eff_count = COUNT_W'(MAX_COUNT);
        end
        else
        begin
            eff_count = cfg_count;
        end
    end

    // request decode
    assign nm1       = active_reg - COUNT_W'(1);
    assign start_seq = req.restart || (emitted_reg == '0) || (emitted_reg >= active_reg);
    assign c_first   = ((cursor_reg >= active_reg) || (cursor_reg == nm1)) ? '0 : cursor_reg;

    // gap evaluation on the successor just read
    assign nx_raw   = COUNT_W'(ram_rd_data);
    assign nx       = (nx_raw >= active_reg) ? nm1 : nx_raw;
    assign gap_unit = ({1'b0, nx} <= ({1'b0, c_reg} + (COUNT_W+1)'(1)));
    assign c_skip   = (nx == nm1) ? '0 : nx;
    assign gap      = nx - c_reg;
    assign mid_sum  = {1'b0, c_reg} + {1'b0, nx};
    assign pick     = (gap <= GAP_NEAR) ? (c_reg + COUNT_W'(1)) : mid_sum[COUNT_W:1];

    assign emit_last = (({1'b0, emitted_reg} + (COUNT_W+1)'(1)) >= {1'b0, active_reg});

    // next state and memory access
    always_comb
    begin
        state_next        = state_reg;
        active_next       = active_reg;
        emitted_next      = emitted_reg;
        cursor_next       = cursor_reg;
        c_next            = c_reg;
        pick_next         = pick_reg;
        out_valid_next    = out_valid_reg && !res.ready;
        out_index_next    = out_index_reg;
        out_position_next = out_position_reg;
        out_last_next     = out_last_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = '0;
        ram_wr_data       = '0;
        ram_rd_en         = 1'b0;
        ram_rd_addr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (start_seq)
                    begin
                        active_next  = eff_count;
                        emitted_next = '0;
                        cursor_next  = '0;
                        pick_next    = '0;
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = '0;
                        ram_wr_data  = AW'(eff_count - COUNT_W'(1));
                        state_next   = S_EMIT;
                    end
                    else if (emitted_reg == COUNT_W'(1))
                    begin
                        cursor_next = '0;
                        pick_next   = nm1;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(c_first);
                        c_next      = c_first;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (gap_unit)
                begin
                    // unit gap: step to the successor, wrapping at the end
                    c_next      = c_skip;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = AW'(c_skip);
                end
                else
                begin
                    // splice: new entry points at the old successor
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = AW'(pick);
                    ram_wr_data = AW'(nx);
                    pick_next   = pick;
                    cursor_next = nx;
                    state_next  = S_LINK;
                end
            end

            S_LINK:
            begin
                // splice: current entry points at the new one
                ram_wr_en   = 1'b1;
                ram_wr_addr = AW'(c_reg);
                ram_wr_data = AW'(pick_reg);
                state_next  = S_EMIT;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_index_next    = pick_reg[INDEX_W-1:0];
                    out_position_next = emitted_reg[POSITION_W-1:0];
                    out_last_next     = emit_last;
                    emitted_next      = emitted_reg + COUNT_W'(1);
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= COUNT_W'(1);
            emitted_reg   <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            emitted_reg   <= emitted_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        c_reg            <= c_next;
        pick_reg         <= pick_next;
        out_index_reg    <= out_index_next;
        out_position_reg <= out_position_next;
        out_last_reg     <= out_last_next;
    end

    // channel outputs
    assign req.ready    = (state_reg == S_IDLE);
    assign res.valid    = out_valid_reg;
    assign res.index    = out_index_reg;
    assign res.position = out_position_reg;
    assign res.last     = out_last_reg;

    // emitted count never passes the latched count
    a_emitted_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= active_reg)
        else $error("emitted count exceeds latched count");

    // a scan never sits on the final index
    a_scan_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (c_reg < nm1))
        else $error("scan position at or past the final index");

    // second splice write always follows the gap search
    a_link_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK) |-> ($past(state_reg) == S_SCAN))
        else $error("link write without a preceding scan");

    // a result is loaded only from the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_EMIT))
        else $error("result loaded outside the emit step");

    // the index waiting to go out lies inside the sequence
    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (pick_reg < active_reg))
        else $error("pending index outside the sequence");

endmodule

`default_nettype wire

// File: verif/bisection_order_index_gen_test.sv
// testbench for the bisection order index generator: predicted orders checked per transfer
`timescale 1ns / 100ps
`default_nettype none

module bisection_order_index_gen_test;
    import boig_pkg::*;

    localparam int MAX_COUNT = 1024;
    localparam int IDLE_PCT  = 25;

    typedef struct packed {
        logic [INDEX_W-1:0]    index;
        logic [POSITION_W-1:0] position;
        logic                  last;
    } order_t;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    boig_req_if req_ch ();
    boig_res_if res_ch ();

    bisection_order_index_gen #(
        .MAX_COUNT (MAX_COUNT)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the count register and of the list walk
    logic [COUNT_W-1:0] count_shadow;
    int unsigned        next_idx [MAX_COUNT];
    int unsigned        walk_pos;
    int unsigned        issued;
    int unsigned        seq_len;

    // orders still owed by the block, oldest first
    order_t      order_pending [$];
    order_t      want_order;

    bit          sender_steady;
    bit          sink_steady;
    int unsigned errors;
    int unsigned requests;
    int unsigned results;
    int unsigned orders_done;
    int unsigned cfg_writes;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // tag the next index with its position and the final flag
    function automatic order_t emit_index(int unsigned idx);
        order_t o;
        o.index    = idx[INDEX_W-1:0];
        o.position = issued[POSITION_W-1:0];
        issued++;
        o.last     = (issued >= seq_len);
        return o;
    endfunction

    // latch the count and open a fresh list 0 -> n-1
    function automatic order_t begin_order();
        if (count_shadow == 0)
            seq_len = 1;
        else if (count_shadow > MAX_COUNT)
            seq_len = MAX_COUNT;
        else
            seq_len = count_shadow;
        next_idx[0] = seq_len - 1;
        walk_pos    = 0;
        issued      = 0;
        return emit_index(0);
    endfunction

    // next index in bisection order for one accepted request
    function automatic order_t bisect_next(bit restart);
        int unsigned n;
        int unsigned c;
        int unsigned nx;
        int unsigned pick;
        int unsigned g;
        n = seq_len;
        if (restart || issued == 0 || issued >= n)
            return begin_order();
        if (issued == 1)
        begin
            walk_pos = 0;
            return emit_index(n - 1);
        end
        c = (walk_pos >= n) ? 0 : walk_pos;
        for (g = 0; g < 2 * n + 4; g++)
        begin
            // wrap the pass at the top of the list
            if (c == n - 1)
            begin
                c = 0;
                continue;
            end
            nx = next_idx[c];
            if (nx >= n)
                nx = n - 1;
            // unit gap, nothing to split
            if (nx <= c + 1)
            begin
                c = nx;
                continue;
            end
            pick = (nx - c <= GAP_NEAR) ? c + 1 : (c + nx) / 2;
            next_idx[pick] = nx;
            next_idx[c]    = pick;
            walk_pos       = nx;
            return emit_index(pick);
        end
        return begin_order();
    endfunction

    // receiver back-pressure
    always @(posedge clk)
        res_ch.ready <= sink_steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // compare each result transfer with the oldest predicted order
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results++;
            if (order_pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: index %0d position %0d last %0b",
                         $time, res_ch.index, res_ch.position, res_ch.last);
            end
            else
            begin
                want_order = order_pending.pop_front();
                if (want_order !== {res_ch.index, res_ch.position, res_ch.last})
                begin
                    errors++;
                    $display("%0t: mismatch: expected index %0d position %0d last %0b, actual index %0d position %0d last %0b",
                             $time, want_order.index, want_order.position, want_order.last,
                             res_ch.index, res_ch.position, res_ch.last);
                end
                if (res_ch.last === 1'b1)
                    orders_done++;
            end
        end
    end

    // one request transfer, with an optional gap ahead of it
    task automatic send_request(bit restart);
        int unsigned gap;
        gap = 0;
        if (!sender_steady && $urandom_range(0, 99) < IDLE_PCT)
            gap = $urandom_range(1, 4);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.restart <= restart;
        do
            @(posedge clk);
        while (!req_ch.ready);
        order_pending.push_back(bisect_next(restart));
        requests++;
    endtask

    // hold off requests until every owed result is in
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (order_pending.size() != 0)
            @(posedge clk);
    endtask

    // apb write of the count register, setup then access
    task automatic write_count(logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_COUNT, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        count_shadow = value[COUNT_W-1:0];
        cfg_writes++;
    endtask

    // first indices with the count left at its reset value
    task automatic test_reset_count();
        repeat (4) send_request(1'b0);
        drain_results();
    endtask

    // counts of one, two, three, zero, above the maximum, and a mid-order write
    task automatic test_corner_counts();
        write_count(1);
        send_request(1'b1);
        send_request(1'b0);
        drain_results();
        write_count(2);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        drain_results();
        write_count(3);
        send_request(1'b1);
        repeat (3) send_request(1'b0);
        drain_results();
        // zero in the count field, garbage above it
        write_count(32'hFFFF_F800);
        send_request(1'b1);
        send_request(1'b0);
        drain_results();
        write_count(2047);
        send_request(1'b1);
        send_request(1'b0);
        drain_results();
        // the order of six keeps its latched length across the write
        write_count(6);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        drain_results();
        write_count(2);
        repeat (5) send_request(1'b0);
        drain_results();
    endtask

    // one whole order at the largest count, first part without any idling
    task automatic test_full_order();
        int unsigned k;
        write_count(MAX_COUNT);
        sender_steady = 1'b1;
        sink_steady   = 1'b1;
        send_request(1'b1);
        for (k = 1; k <= MAX_COUNT; k++)
        begin
            if (k == 300)
            begin
                sender_steady = 1'b0;
                sink_steady   = 1'b0;
            end
            send_request(1'b0);
        end
        drain_results();
    endtask

    // random phases: mostly small counts, sometimes corners, rare restarts
    task automatic test_random_orders(int unsigned items);
        int unsigned        stop_at;
        int unsigned        burst;
        int unsigned        pick;
        logic [PDATA_W-1:0] value;
        stop_at = requests + items;
        while (requests < stop_at)
        begin
            pick  = $urandom_range(0, 9);
            value = $urandom_range(0, 1) ? $urandom : '0;
            if (pick < 8)
                value[COUNT_W-1:0] = $urandom_range(1, 40);
            else if (pick == 8)
            begin
                case ($urandom_range(0, 6))
                    0: value[COUNT_W-1:0] = 0;
                    1: value[COUNT_W-1:0] = 1;
                    2: value[COUNT_W-1:0] = 2;
                    3: value[COUNT_W-1:0] = 3;
                    4: value[COUNT_W-1:0] = 1023;
                    5: value[COUNT_W-1:0] = 1024;
                    default: value[COUNT_W-1:0] = 2047;
                endcase
            end
            write_count(value);
            sender_steady = ($urandom_range(0, 7) == 0);
            sink_steady   = ($urandom_range(0, 7) == 0);
            burst = $urandom_range(10, 60);
            repeat (burst)
                send_request($urandom_range(0, 99) < 4);
            // occasional burst of restarts
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(2, 5)) send_request(1'b1);
            drain_results();
        end
        sender_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    initial
    begin
        req_ch.valid   = 1'b0;
        req_ch.restart = 1'b0;
        res_ch.ready   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        count_shadow   = COUNT_RESET;
        walk_pos       = 0;
        issued         = 0;
        seq_len        = 1;
        sender_steady  = 1'b0;
        sink_steady    = 1'b0;
        errors         = 0;
        requests       = 0;
        results        = 0;
        orders_done    = 0;
        cfg_writes     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_count();
        test_corner_counts();
        test_full_order();
        test_random_orders(700);

        // settle, watching for stray results
        drain_results();
        repeat (40) @(posedge clk);

        $display("run covered %0d requests and %0d results over %0d count writes",
                 requests, results, cfg_writes);
        $display("%0d orders ran to their final index, one of them at the full count",
                 orders_done);
        if (errors == 0 && order_pending.size() == 0)
            $display("bisection_order_index_gen_test: PASS");
        else
            $display("bisection_order_index_gen_test: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("bisection_order_index_gen_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
